// ===== hdl/mofm_pkg.sv =====
// ----------------------------------------------------------------------------
// mofm_pkg
// Shared types and constants of the market order FIFO matcher.
// ----------------------------------------------------------------------------
package mofm_pkg;

	localparam int QTY_W      = 32;
	localparam int SEC_W      = 2;

	// command queue between the front and the engine
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PW    = 1;
	localparam int CMDQ_CW    = 2;

	// one classified order as it travels from the front to the engine
	typedef struct packed {
		logic             nop;
		logic [SEC_W-1:0] security_id;
		logic             is_bid;
		logic [QTY_W-1:0] quantity;
	} cmd_t;

endpackage

// ===== hdl/market_order_fifo_matcher.sv =====
// Flow: an order that touches no book goes from ST_IDLE straight to ST_RESULT; other
// orders pass ST_LOAD_OPP, then ST_MATCH/ST_FRONT per resting entry touched, ST_WB_OPP,
// and, with a remainder, ST_LOAD_OWN and ST_APPEND before ST_RESULT.
// Throughput: the engine holds one order at a time; each resting entry touched costs one
// memory read and one compare/update. The front and a 2-entry queue take new orders meanwhile.
// Reset: asynchronous; all books read as empty, no clearing pass is needed.
// ----------------------------------------------------------------------------
// market_order_fifo_matcher
// Per-security FIFO order books; each market order fills against the opposite
// side and rests any remainder on its own side while that side has room.
// ----------------------------------------------------------------------------
module market_order_fifo_matcher import mofm_pkg::*; #(
	parameter int NUM_SECURITIES = 4,
	parameter int QUEUE_DEPTH    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [SEC_W-1:0] security_id,
	input  logic             is_bid,
	input  logic [QTY_W-1:0] order_quantity,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [QTY_W-1:0] filled_quantity,
	output logic [QTY_W-1:0] rested_quantity,
	output logic             book_full
);

	logic push_valid;
	cmd_t push_cmd;
	logic push_ready;
	logic pop_valid;
	cmd_t pop_cmd;
	logic pop;

	mofm_front #(
		.NUM_SECURITIES (NUM_SECURITIES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.security_id    (security_id),
		.is_bid         (is_bid),
		.order_quantity (order_quantity),
		.push_valid     (push_valid),
		.push_cmd       (push_cmd),
		.push_ready     (push_ready)
	);

	mofm_cmd_queue u_cmd_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop)
	);

	mofm_engine #(
		.NUM_SECURITIES (NUM_SECURITIES),
		.QUEUE_DEPTH    (QUEUE_DEPTH)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (pop_valid),
		.cmd             (pop_cmd),
		.cmd_pop         (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.filled_quantity (filled_quantity),
		.rested_quantity (rested_quantity),
		.book_full       (book_full)
	);

endmodule

// ===== hdl/mofm_front.sv =====
// ----------------------------------------------------------------------------
// mofm_front
// Accepts orders, flags those that touch no book and registers the command.
// ----------------------------------------------------------------------------
module mofm_front import mofm_pkg::*; #(
	parameter int NUM_SECURITIES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [SEC_W-1:0] security_id,
	input  logic             is_bid,
	input  logic [QTY_W-1:0] order_quantity,
	output logic             push_valid,
	output cmd_t             push_cmd,
	input  logic             push_ready
);

	logic vld_s1;
	cmd_t cmd_s1;
	logic advance;
	logic out_of_range;

	assign advance      = !vld_s1 || push_ready;
	assign in_stall     = !advance;
	assign out_of_range = (32'(security_id) >= 32'(NUM_SECURITIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			cmd_s1.nop         <= out_of_range || (order_quantity == '0);
			cmd_s1.security_id <= security_id;
			cmd_s1.is_bid      <= is_bid;
			cmd_s1.quantity    <= order_quantity;
		end
	end

	assign push_valid = vld_s1;
	assign push_cmd   = cmd_s1;

endmodule

// ===== hdl/mofm_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// mofm_cmd_queue
// Short command queue that decouples the front from the matching engine.
// ----------------------------------------------------------------------------
module mofm_cmd_queue import mofm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cmd_t push_cmd,
	output logic push_ready,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop
);

	cmd_t               slots_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0] wr_ptr_q;
	logic [CMDQ_PW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CMDQ_CW'(CMDQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hdl/mofm_engine.sv =====
// ----------------------------------------------------------------------------
// mofm_engine
// Matching engine: walks the opposite FIFO, then appends any remainder to the
// order's own FIFO if it has room, and registers the result.
// ----------------------------------------------------------------------------
module mofm_engine import mofm_pkg::*; #(
	parameter int NUM_SECURITIES = 4,
	parameter int QUEUE_DEPTH    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [QTY_W-1:0] filled_quantity,
	output logic [QTY_W-1:0] rested_quantity,
	output logic             book_full
);

	localparam int NQ = NUM_SECURITIES * 2;
	localparam int QW = $clog2(NQ);
	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MW = HW + CW;
	localparam int AW = $clog2(NQ * QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [HW:0]   DEPTH_T = (HW + 1)'(QUEUE_DEPTH);
	localparam logic [HW-1:0] LAST_H  = HW'(QUEUE_DEPTH - 1);
	localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_LOAD_OPP = 8'b0000_0010,
		ST_MATCH    = 8'b0000_0100,
		ST_FRONT    = 8'b0000_1000,
		ST_WB_OPP   = 8'b0001_0000,
		ST_LOAD_OWN = 8'b0010_0000,
		ST_APPEND   = 8'b0100_0000,
		ST_RESULT   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [QW-1:0]     own_q;
	logic [QW-1:0]     opp_q;
	logic [QTY_W-1:0]  left_q;
	logic [QTY_W-1:0]  filled_q;
	logic [QTY_W-1:0]  rested_q;
	logic              full_q;
	logic [HW-1:0]     head_q;
	logic [CW-1:0]     count_q;

	// resting quantities and per-queue {head, count}
	logic [QTY_W-1:0]  data_mem [NQ * QUEUE_DEPTH];
	logic [QTY_W-1:0]  data_rd_q;
	logic [MW-1:0]     meta_mem [NQ];
	logic [MW-1:0]     meta_rd_q;
	logic [NQ-1:0]     meta_vld_q;
	logic              meta_hit_q;

	logic              out_valid_q;
	logic [QTY_W-1:0]  filled_out_q;
	logic [QTY_W-1:0]  rested_out_q;
	logic              full_out_q;

	logic [QW-1:0]     cmd_own;
	logic [QW-1:0]     cmd_opp;
	logic [QW-1:0]     meta_raddr;
	logic [QW-1:0]     meta_waddr;
	logic [MW-1:0]     meta_wdata;
	logic              meta_we;
	logic [HW:0]       tail_sum;
	logic [HW-1:0]     tail;
	logic [HW-1:0]     head_next;
	logic              front_gt;
	logic              own_full;
	logic [QW-1:0]     data_q_sel;
	logic [HW-1:0]     data_pos;
	logic [AW-1:0]     data_addr;
	logic              data_we;
	logic [QTY_W-1:0]  data_wdata;
	logic              out_load;

	assign cmd_own = QW'({cmd.security_id, ~cmd.is_bid});
	assign cmd_opp = QW'({cmd.security_id, cmd.is_bid});
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	assign tail_sum  = (HW + 1)'(head_q) + (HW + 1)'(count_q);
	assign tail      = (tail_sum >= DEPTH_T) ? HW'(tail_sum - DEPTH_T) : HW'(tail_sum);
	assign head_next = (head_q == LAST_H) ? '0 : head_q + 1'b1;
	assign front_gt  = (data_rd_q > left_q);
	assign own_full  = (count_q >= DEPTH_C);

	assign meta_raddr = (state_q == ST_IDLE) ? cmd_opp : own_q;
	assign meta_waddr = (state_q == ST_WB_OPP) ? opp_q : own_q;
	assign meta_wdata = (state_q == ST_WB_OPP) ? {head_q, count_q}
	                                           : {head_q, count_q + 1'b1};
	assign meta_we    = (state_q == ST_WB_OPP) || ((state_q == ST_APPEND) && !own_full);

	assign data_q_sel = (state_q == ST_APPEND) ? own_q : opp_q;
	assign data_pos   = (state_q == ST_APPEND) ? tail : head_q;
	assign data_addr  = AW'(data_q_sel) * DEPTH_A + AW'(data_pos);
	assign data_we    = ((state_q == ST_FRONT) && front_gt) ||
	                    ((state_q == ST_APPEND) && !own_full);
	assign data_wdata = (state_q == ST_FRONT) ? data_rd_q - left_q : left_q;

	assign out_load = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_addr] <= data_wdata;
		end
		data_rd_q <= data_mem[data_addr];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		meta_rd_q <= meta_mem[meta_raddr];
	end

	// a queue never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
			meta_hit_q <= 1'b0;
		end else begin
			if (meta_we) begin
				meta_vld_q[meta_waddr] <= 1'b1;
			end
			meta_hit_q <= meta_vld_q[meta_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= cmd.nop ? ST_RESULT : ST_LOAD_OPP;
					end
				end
				ST_LOAD_OPP: state_q <= ST_MATCH;
				ST_MATCH: begin
					if ((left_q == '0) || (count_q == '0)) begin
						state_q <= ST_WB_OPP;
					end else begin
						state_q <= ST_FRONT;
					end
				end
				ST_FRONT:    state_q <= ST_MATCH;
				ST_WB_OPP:   state_q <= (left_q == '0) ? ST_RESULT : ST_LOAD_OWN;
				ST_LOAD_OWN: state_q <= ST_APPEND;
				ST_APPEND:   state_q <= ST_RESULT;
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				own_q    <= cmd_own;
				opp_q    <= cmd_opp;
				left_q   <= cmd.nop ? '0 : cmd.quantity;
				filled_q <= '0;
				rested_q <= '0;
				full_q   <= 1'b0;
			end
			ST_LOAD_OPP, ST_LOAD_OWN: begin
				head_q  <= meta_hit_q ? meta_rd_q[MW-1:CW] : '0;
				count_q <= meta_hit_q ? meta_rd_q[CW-1:0] : '0;
			end
			ST_FRONT: begin
				if (front_gt) begin
					// reduce the front entry in place
					filled_q <= filled_q + left_q;
					left_q   <= '0;
				end else begin
					// consume and drop the front entry
					filled_q <= filled_q + data_rd_q;
					left_q   <= left_q - data_rd_q;
					head_q   <= head_next;
					count_q  <= count_q - 1'b1;
				end
			end
			ST_APPEND: begin
				if (own_full) begin
					full_q <= 1'b1;
				end else begin
					rested_q <= left_q;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			filled_out_q <= filled_q;
			rested_out_q <= rested_q;
			full_out_q   <= full_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign filled_quantity = filled_out_q;
	assign rested_quantity = rested_out_q;
	assign book_full       = full_out_q;

endmodule

// ===== test/tb_market_order_fifo_matcher.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_market_order_fifo_matcher
// Self-checking bench for the per-security order books. A behavioral book model
// predicts fills, rests and full-book drops for every accepted order. Directed
// orders cover edge quantities and a full book. Random orders follow, with
// per-block side and security bias, under several sender/receiver idle mixes
// and one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_market_order_fifo_matcher import mofm_pkg::*;;

	localparam int NUM_SECURITIES = 4;
	localparam int QUEUE_DEPTH    = 16;
	localparam int RANDOM_ORDERS  = 325;
	localparam int HOLD_CYCLES    = 400;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int DRAIN_CYCLES   = 60;

	// Behavioral copy of the books plus the queue of predicted results.
	class order_book_scoreboard;
		logic [QTY_W-1:0] resting [2*NUM_SECURITIES][QUEUE_DEPTH];
		int unsigned      head    [2*NUM_SECURITIES];
		int unsigned      used    [2*NUM_SECURITIES];
		logic [QTY_W-1:0] want_filled [$];
		logic [QTY_W-1:0] want_rested [$];
		logic             want_full   [$];
		int errors = 0;
		int orders = 0;
		int fills  = 0;
		int rests  = 0;
		int drops  = 0;

		function new();
			foreach (head[q]) begin
				head[q] = 0;
				used[q] = 0;
			end
		endfunction

		function int pending();
			return want_filled.size();
		endfunction

		function void note_order(logic [SEC_W-1:0] sec, logic bid, logic [QTY_W-1:0] qty);
			int               own;
			int               opp;
			logic [QTY_W-1:0] left;
			logic [QTY_W-1:0] filled;
			logic [QTY_W-1:0] rested;
			logic             full;
			left   = qty;
			filled = '0;
			rested = '0;
			full   = 1'b0;
			orders++;
			if (int'(sec) < NUM_SECURITIES && left != '0) begin
				own = int'(sec) * 2 + (bid ? 0 : 1);
				opp = int'(sec) * 2 + (bid ? 1 : 0);
				// consume the opposite side oldest first
				while (left != '0 && used[opp] != 0) begin
					if (resting[opp][head[opp]] > left) begin
						resting[opp][head[opp]] -= left;
						filled += left;
						left = '0;
					end else begin
						filled += resting[opp][head[opp]];
						left -= resting[opp][head[opp]];
						head[opp] = (head[opp] + 1) % QUEUE_DEPTH;
						used[opp]--;
					end
				end
				if (left != '0) begin
					if (used[own] >= QUEUE_DEPTH) begin
						full = 1'b1;
					end else begin
						resting[own][(head[own] + used[own]) % QUEUE_DEPTH] = left;
						used[own]++;
						rested = left;
					end
				end
			end
			if (filled != '0) fills++;
			if (rested != '0) rests++;
			if (full) drops++;
			want_filled.push_back(filled);
			want_rested.push_back(rested);
			want_full.push_back(full);
		endfunction

		function void check_fill(logic [QTY_W-1:0] filled, logic [QTY_W-1:0] rested,
				logic full);
			logic [QTY_W-1:0] exp_filled;
			logic [QTY_W-1:0] exp_rested;
			logic             exp_full;
			if (want_filled.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result filled=%0d rested=%0d full=%0b",
						$time, filled, rested, full);
				return;
			end
			exp_filled = want_filled.pop_front();
			exp_rested = want_rested.pop_front();
			exp_full   = want_full.pop_front();
			if (filled !== exp_filled || rested !== exp_rested || full !== exp_full) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch filled %0d/%0d rested %0d/%0d full %0b/%0b (exp/got)",
						$time, exp_filled, filled, exp_rested, rested, exp_full, full);
			end
		endfunction
	endclass

	logic             clk             = 1'b0;
	logic             arst_n          = 1'b0;
	logic             in_valid        = 1'b0;
	logic             in_stall;
	logic [SEC_W-1:0] security_id     = '0;
	logic             is_bid          = 1'b0;
	logic [QTY_W-1:0] order_quantity  = '0;
	logic             out_valid;
	logic             out_stall       = 1'b0;
	logic [QTY_W-1:0] filled_quantity;
	logic [QTY_W-1:0] rested_quantity;
	logic             book_full;

	int unsigned idle_pct    = 0;
	int unsigned stall_pct   = 0;
	int unsigned block_left  = 0;
	int unsigned focus_sec   = 4;
	int unsigned bid_pct     = 50;
	int unsigned cycle_count = 0;
	bit          pressure_go = 1'b0;
	logic        long_hold   = 1'b0;

	order_book_scoreboard book_sb;

	market_order_fifo_matcher #(
		.NUM_SECURITIES(NUM_SECURITIES),
		.QUEUE_DEPTH   (QUEUE_DEPTH)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.security_id    (security_id),
		.is_bid         (is_bid),
		.order_quantity (order_quantity),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filled_quantity(filled_quantity),
		.rested_quantity(rested_quantity),
		.book_full      (book_full)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, book_sb.pending());
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= long_hold || ($urandom_range(99) < stall_pct);
	end

	// long output hold: let the block back up until it stalls the input
	initial begin
		wait (pressure_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book_sb.check_fill(filled_quantity, rested_quantity, book_full);
	end

	task automatic send_order(logic [SEC_W-1:0] sec, logic bid, logic [QTY_W-1:0] qty);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		security_id    <= sec;
		is_bid         <= bid;
		order_quantity <= qty;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		book_sb.note_order(sec, bid, qty);
	endtask

	task automatic send_random_order();
		logic [SEC_W-1:0] sec;
		logic             bid;
		logic [QTY_W-1:0] qty;
		int unsigned      r;
		// each block may favor one side and often a single security, to fill books
		if (block_left == 0) begin
			block_left = 64;
			focus_sec  = $urandom_range(4);
			case ($urandom_range(2))
				0: begin
					bid_pct = 5;
				end
				1: begin
					bid_pct = 50;
				end
				default: begin
					bid_pct = 95;
				end
			endcase
		end
		block_left--;
		sec = (focus_sec == 4) ? SEC_W'($urandom_range(NUM_SECURITIES - 1)) : SEC_W'(focus_sec);
		bid = ($urandom_range(99) < bid_pct);
		r   = $urandom_range(99);
		if (r < 4)
			qty = '0;
		else if (r < 8)
			qty = '1;
		else if (r < 20)
			qty = $urandom;
		else if (r < 55)
			qty = $urandom_range(20, 1);
		else
			qty = $urandom_range(1000, 1);
		send_order(sec, bid, qty);
	endtask

	initial begin
		book_sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, extreme quantities, reduce in place, exact pop
		send_order(2'd1, 1'b1, 32'd0);
		send_order(2'd0, 1'b0, 32'hFFFF_FFFF);
		send_order(2'd0, 1'b1, 32'd1);
		send_order(2'd0, 1'b1, 32'hFFFF_FFFF);
		send_order(2'd0, 1'b0, 32'd1);
		send_order(2'd2, 1'b0, 32'd0);
		// fill one bid book, overflow it, then sweep it with one ask
		for (int k = 0; k < QUEUE_DEPTH; k++)
			send_order(2'd3, 1'b1, 32'd1 << k);
		send_order(2'd3, 1'b1, 32'd5);
		send_order(2'd3, 1'b0, 32'h0001_0007);
		send_order(2'd2, 1'b1, 32'hA5A5_5A5A);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 50;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 50;
				end
				default: begin
					idle_pct = 26;
					stall_pct = 26;
				end
			endcase
			for (int i = 0; i < RANDOM_ORDERS; i++) begin
				if (ph == 0 && i == 100) pressure_go = 1'b1;
				send_random_order();
			end
		end
		in_valid <= 1'b0;

		while (book_sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		book_sb.errors += book_sb.pending();

		$display("Covered %0d orders: %0d filled, %0d rested, %0d dropped on a full book",
			book_sb.orders, book_sb.fills, book_sb.rests, book_sb.drops);
		$display("Idle mixes: none, sender, receiver, both; one %0d-cycle output hold",
			HOLD_CYCLES);
		if (book_sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d failures", book_sb.errors);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mofm_pkg.sv
hdl/mofm_front.sv
hdl/mofm_cmd_queue.sv
hdl/mofm_engine.sv
hdl/market_order_fifo_matcher.sv
test/tb_market_order_fifo_matcher.sv
